[sv/pwmfd_pkg.sv]
// shared types and constants for the pwm frequency and duty calculator
package pwmfd_pkg;

	localparam int PERIOD_W  = 16;
	localparam int PRESC_W   = 4;
	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = 5;
	localparam int DIV_STEPS = 32;

	localparam logic [1:0] CMD_FREQ_NORM = 2'd0;
	localparam logic [1:0] CMD_FREQ_INV  = 2'd1;
	localparam logic [1:0] CMD_DUTY_PCT  = 2'd2;
	localparam logic [1:0] CMD_DUTY_256  = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_HIGH = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

	localparam logic [DIV_W-1:0]    DUTY_DEN_PCT    = 32'd100;
	localparam logic [DIV_W-1:0]    DUTY_DEN_256    = 32'd256;
	localparam logic [PERIOD_W-1:0] DUTY_AFTER_FREQ = 16'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  channel;
		logic [31:0] value;
	} cmd_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [1:0]          channel_out;
		logic [PRESC_W-1:0]  prescaler_exp;
		logic [PERIOD_W-1:0] period_count;
		logic [PERIOD_W-1:0] duty_count;
		logic                polarity_high;
	} res_req_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;

endpackage

[sv/pwmfd_stream_if.sv]
// valid/ready stream interface carrying one request payload
interface pwmfd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/pwmfd_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module pwmfd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pwmfd_pkg::div_ctrl_t          ctrl_in,
	output pwmfd_pkg::div_ctrl_t          ctrl_out,
	input  logic [pwmfd_pkg::DIV_W-1:0]   dividend,
	input  logic [pwmfd_pkg::DIV_W-1:0]   divisor,
	output logic [pwmfd_pkg::DIV_W-1:0]   quotient
);
	localparam int W = pwmfd_pkg::DIV_W;

	logic                          active_q;
	logic                          done_q;
	logic [pwmfd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  dsr_q;
	logic [W:0]                    partial;
	logic [W+1:0]                  diff;
	logic                          fits;

	assign partial = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, partial} - {2'b00, dsr_q};
	assign fits    = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl_in.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pwmfd_pkg::DIV_CNT_W'(pwmfd_pkg::DIV_STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (active_q) begin
			rem_q <= fits ? diff[W-1:0] : partial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign ctrl_out.start = active_q;
	assign ctrl_out.done  = done_q;
	assign quotient       = quo_q;
endmodule

[sv/pwm_frequency_and_duty_calc.sv]
// pwm frequency and duty calculator top level
// One command is taken at a time; ready is low until its result is loaded into the output
// register. The shared 32-step restoring divider sets the latency. After the divider, a
// frequency command shifts its quotient once per prescaler step (at most 11 for a clock up to
// 100 MHz) and a duty command passes a multiply step; a rejected frequency or an unused
// channel goes straight to the completion step. A stalled output side holds a command in the
// completion step. A new command may be taken while the previous result still waits on the
// output side.
module pwm_frequency_and_duty_calc #(
	parameter int CLOCK_HZ = 48000000,
	parameter int CHANNELS = 4
) (
	input logic             clk,
	input logic             arst_n,
	pwmfd_stream_if.sink    command,
	pwmfd_stream_if.source  result
);
	localparam int DEPTH = (CHANNELS < 4) ? CHANNELS : 4;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = pwmfd_pkg::PERIOD_W;
	localparam int QW    = pwmfd_pkg::PRESC_W;
	localparam int DW    = pwmfd_pkg::DIV_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [PW-1:0] period_store_q [DEPTH];
	logic [QW-1:0] prescaler_store_q [DEPTH];
	logic          polarity_store_q [DEPTH];
	logic          res_valid_q;
	pwmfd_pkg::res_req_t res_q;

	logic [1:0]    cmd_q;
	logic [1:0]    ch_q;
	logic          in_range_q;
	logic [1:0]    status_q;
	logic [PW-1:0] duty_q;
	logic [PW-1:0] duty_in_q;
	logic [DW-1:0] work_q;
	logic [QW-1:0] pre_q;

	logic             accept;
	logic             in_range;
	logic             is_freq;
	logic             freq_zero;
	logic             freq_high;
	logic [IDX_W-1:0] idx_in;
	logic [IDX_W-1:0] idx_q;
	logic [DW-1:0]    div_dividend;
	logic [DW-1:0]    div_divisor;
	logic [DW-1:0]    div_quotient;
	logic [47:0]      prod;
	logic             out_free;
	pwmfd_pkg::div_ctrl_t div_in;
	pwmfd_pkg::div_ctrl_t div_out;

	assign command.ready = (state_q == ST_IDLE);
	assign accept        = command.valid && command.ready;
	assign in_range      = {3'b000, command.data.channel} < 5'(CHANNELS);
	assign is_freq       = command.data.cmd inside {pwmfd_pkg::CMD_FREQ_NORM,
		pwmfd_pkg::CMD_FREQ_INV};
	assign freq_zero     = (command.data.value == 32'd0);
	assign freq_high     = (command.data.value > 32'(CLOCK_HZ));
	assign idx_in        = command.data.channel[IDX_W-1:0];
	assign idx_q         = ch_q[IDX_W-1:0];

	assign div_in.start  = accept && in_range && (!is_freq || (!freq_zero && !freq_high));
	assign div_in.done   = 1'b0;
	assign div_dividend  = is_freq ? 32'(CLOCK_HZ) : {period_store_q[idx_in], 16'h0000};
	assign div_divisor   = is_freq ? command.data.value :
		((command.data.cmd == pwmfd_pkg::CMD_DUTY_PCT) ? pwmfd_pkg::DUTY_DEN_PCT :
		pwmfd_pkg::DUTY_DEN_256);

	assign prod     = 48'(duty_in_q) * 48'(work_q);
	assign out_free = !res_valid_q || result.ready;

	pwmfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (div_in),
		.ctrl_out (div_out),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient)
	);

	// sequencer, channel store and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				period_store_q[i]    <= '0;
				prescaler_store_q[i] <= '0;
				polarity_store_q[i]  <= 1'b0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= div_in.start ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_out.done) begin
						state_q <= (cmd_q inside {pwmfd_pkg::CMD_FREQ_NORM,
							pwmfd_pkg::CMD_FREQ_INV}) ? ST_NORM : ST_MUL;
					end
				end
				ST_NORM: begin
					if (work_q[DW-1:PW] == '0) begin
						period_store_q[idx_q]    <= work_q[PW-1:0];
						prescaler_store_q[idx_q] <= pre_q;
						polarity_store_q[idx_q]  <= (cmd_q == pwmfd_pkg::CMD_FREQ_NORM);
						state_q                  <= ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= command.data.cmd;
					ch_q       <= command.data.channel;
					in_range_q <= in_range;
					duty_in_q  <= command.data.value[PW-1:0];
					duty_q     <= '0;
					if (in_range && is_freq && freq_zero) begin
						status_q <= pwmfd_pkg::STATUS_ZERO;
					end else if (in_range && is_freq && freq_high) begin
						status_q <= pwmfd_pkg::STATUS_HIGH;
					end else begin
						status_q <= pwmfd_pkg::STATUS_OK;
					end
				end
			end
			ST_DIV: begin
				if (div_out.done) begin
					work_q <= div_quotient;
					pre_q  <= '0;
				end
			end
			ST_NORM: begin
				if (work_q[DW-1:PW] != '0) begin
					work_q <= work_q >> 1;
					pre_q  <= pre_q + 1'b1;
				end else begin
					duty_q <= pwmfd_pkg::DUTY_AFTER_FREQ;
				end
			end
			ST_MUL: begin
				duty_q <= prod[31:16];
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.status      <= status_q;
					res_q.channel_out <= ch_q;
					res_q.duty_count  <= duty_q;
					if (in_range_q) begin
						res_q.prescaler_exp <= prescaler_store_q[idx_q];
						res_q.period_count  <= period_store_q[idx_q];
						res_q.polarity_high <= polarity_store_q[idx_q];
					end else begin
						res_q.prescaler_exp <= '0;
						res_q.period_count  <= '0;
						res_q.polarity_high <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_out.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(command.valid && command.ready) |=> !command.ready)
		else $error("second request taken while one is in flight");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the completion step");
`endif
endmodule

[tb/tb_top.sv]
// self-checking testbench for the pwm frequency and duty calculator
module tb_top;

	localparam logic [31:0] MASTER_HZ = 32'd48_000_000;
	localparam int N_CH = 4;
	localparam int RANDOM_ITEMS = 1530;
	localparam int IDLE_PCT = 21;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		pwmfd_pkg::cmd_req_t req;
		logic                fixed;
		pwmfd_pkg::res_req_t res;
	} plan_row_t;

	localparam plan_row_t DIRECTED [21] = '{
		'{'{pwmfd_pkg::CMD_DUTY_PCT, 2'd0, 32'h0000_ffff}, 1'b1,
			'{pwmfd_pkg::STATUS_OK, 2'd0, 4'd0, 16'd0, 16'd0, 1'b0}},
		'{'{pwmfd_pkg::CMD_DUTY_256, 2'd3, 32'hffff_ffff}, 1'b1,
			'{pwmfd_pkg::STATUS_OK, 2'd3, 4'd0, 16'd0, 16'd0, 1'b0}},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd1, 32'd0}, 1'b1,
			'{pwmfd_pkg::STATUS_ZERO, 2'd1, 4'd0, 16'd0, 16'd0, 1'b0}},
		'{'{pwmfd_pkg::CMD_FREQ_INV, 2'd2, 32'd48_000_001}, 1'b1,
			'{pwmfd_pkg::STATUS_HIGH, 2'd2, 4'd0, 16'd0, 16'd0, 1'b0}},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd2, 32'hffff_ffff}, 1'b1,
			'{pwmfd_pkg::STATUS_HIGH, 2'd2, 4'd0, 16'd0, 16'd0, 1'b0}},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd0, 32'd1}, 1'b1,
			'{pwmfd_pkg::STATUS_OK, 2'd0, 4'd10, 16'd46875, 16'd2, 1'b1}},
		'{'{pwmfd_pkg::CMD_FREQ_INV, 2'd3, 32'd48_000_000}, 1'b1,
			'{pwmfd_pkg::STATUS_OK, 2'd3, 4'd0, 16'd1, 16'd2, 1'b0}},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd1, 32'd1465}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_INV, 2'd2, 32'd1464}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd1, 32'd732}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_PCT, 2'd0, 32'd100}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_PCT, 2'd0, 32'h0000_ffff}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_256, 2'd0, 32'hffff_ffff}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_256, 2'd1, 32'h1234_0080}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd0, 32'd0}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_INV, 2'd3, 32'hffff_ffff}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_PCT, 2'd3, 32'd50}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_INV, 2'd0, 32'h00ff_ffff}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_256, 2'd2, 32'd256}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_FREQ_NORM, 2'd1, 32'd3}, 1'b0, '0},
		'{'{pwmfd_pkg::CMD_DUTY_PCT, 2'd1, 32'haaaa_5555}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic quiet;
	int   mismatch_count;

	logic [pwmfd_pkg::PERIOD_W-1:0] period_mem [N_CH];
	logic [pwmfd_pkg::PRESC_W-1:0]  presc_mem [N_CH];
	logic                           polarity_mem [N_CH];
	pwmfd_pkg::res_req_t            pending_results [$];

	pwmfd_stream_if #(.T(pwmfd_pkg::cmd_req_t)) cmd_bus ();
	pwmfd_stream_if #(.T(pwmfd_pkg::res_req_t)) res_bus ();

	pwm_frequency_and_duty_calc #(
		.CLOCK_HZ(48000000),
		.CHANNELS(N_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.command(cmd_bus),
		.result(res_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [15:0] scaled_duty(logic [15:0] per, logic [15:0] amount,
			logic [31:0] den);
		logic [31:0] step;
		step = {per, 16'h0000} / den;
		step = {16'h0000, amount} * step;
		return step[31:16];
	endfunction

	// updates the channel store and returns the result the command should give
	function automatic pwmfd_pkg::res_req_t apply_command(pwmfd_pkg::cmd_req_t req);
		pwmfd_pkg::res_req_t r;
		logic [31:0]         quo;
		logic [31:0]         upper;
		int unsigned         shift;
		r = '0;
		r.channel_out = req.channel;
		if (req.cmd == pwmfd_pkg::CMD_FREQ_NORM || req.cmd == pwmfd_pkg::CMD_FREQ_INV) begin
			if (req.value == 32'd0) begin
				r.status = pwmfd_pkg::STATUS_ZERO;
			end else if (req.value > MASTER_HZ) begin
				r.status = pwmfd_pkg::STATUS_HIGH;
			end else begin
				quo = MASTER_HZ / req.value;
				shift = 0;
				if (quo > 32'h0000_7fff) begin
					upper = quo >> 15;
					while (upper > 32'd1) begin
						shift++;
						upper = upper >> 1;
					end
				end
				period_mem[req.channel] = 16'(quo >> shift);
				presc_mem[req.channel] = 4'(shift);
				polarity_mem[req.channel] = (req.cmd == pwmfd_pkg::CMD_FREQ_NORM);
				r.duty_count = pwmfd_pkg::DUTY_AFTER_FREQ;
			end
		end else begin
			r.duty_count = scaled_duty(period_mem[req.channel], req.value[15:0],
				(req.cmd == pwmfd_pkg::CMD_DUTY_PCT) ? pwmfd_pkg::DUTY_DEN_PCT :
				pwmfd_pkg::DUTY_DEN_256);
		end
		r.prescaler_exp = presc_mem[req.channel];
		r.period_count = period_mem[req.channel];
		r.polarity_high = polarity_mem[req.channel];
		return r;
	endfunction

	task automatic issue_command(input pwmfd_pkg::cmd_req_t req, input logic fixed,
			input pwmfd_pkg::res_req_t fixed_res);
		pwmfd_pkg::res_req_t predicted;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.data <= req;
		do @(posedge clk); while (!cmd_bus.ready);
		predicted = apply_command(req);
		pending_results.push_back(fixed ? fixed_res : predicted);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// result side: random back-pressure
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		pwmfd_pkg::res_req_t want;
		pwmfd_pkg::res_req_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = res_bus.data;
			if (pending_results.size() == 0) begin
				$error("unexpected request on result side: channel %0d", got.channel_out);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.channel_out !== want.channel_out) begin
					$error("channel_out: expected %0d, actual %0d", want.channel_out,
						got.channel_out);
					mismatch_count++;
				end
				if (got.prescaler_exp !== want.prescaler_exp) begin
					$error("prescaler_exp: expected %0d, actual %0d", want.prescaler_exp,
						got.prescaler_exp);
					mismatch_count++;
				end
				if (got.period_count !== want.period_count) begin
					$error("period_count: expected %0d, actual %0d", want.period_count,
						got.period_count);
					mismatch_count++;
				end
				if (got.duty_count !== want.duty_count) begin
					$error("duty_count: expected %0d, actual %0d", want.duty_count,
						got.duty_count);
					mismatch_count++;
				end
				if (got.polarity_high !== want.polarity_high) begin
					$error("polarity_high: expected %0d, actual %0d", want.polarity_high,
						got.polarity_high);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		pwmfd_pkg::cmd_req_t req;
		int                  guard;
		mismatch_count = 0;
		quiet = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.data = '0;
		for (int i = 0; i < N_CH; i++) begin
			period_mem[i] = '0;
			presc_mem[i] = '0;
			polarity_mem[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			issue_command(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].res);
		hold_until_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 500 && n < 800);
			if (n == 1000)
				hold_until_drained();
			req.cmd = 2'($urandom_range(3));
			req.channel = 2'($urandom_range(N_CH - 1));
			if (req.cmd == pwmfd_pkg::CMD_FREQ_NORM || req.cmd == pwmfd_pkg::CMD_FREQ_INV) begin
				case ($urandom_range(9))
					0: req.value = 32'd0;
					1: req.value = $urandom_range(32'hffff_ffff, MASTER_HZ + 32'd1);
					default: req.value = $urandom >> $urandom_range(31);
				endcase
			end else begin
				req.value = $urandom;
				if ($urandom_range(1))
					req.value[15:0] = 16'($urandom_range(300));
			end
			issue_command(req, 1'b0, '0);
		end
		quiet = 1'b0;
		@(negedge clk);
		cmd_bus.valid <= 1'b0;

		guard = 0;
		while (pending_results.size() != 0 && guard < 100_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
sv/pwmfd_pkg.sv
sv/pwmfd_stream_if.sv
sv/pwmfd_div.sv
sv/pwm_frequency_and_duty_calc.sv
tb/tb_top.sv
